### hdl/spi_master_fifo_controller_core_macros.svh
// assertion macros shared by the spi master controller rtl
`ifndef SPI_MASTER_FIFO_CONTROLLER_CORE_MACROS_SVH
`define SPI_MASTER_FIFO_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SMFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SMFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/smfc_pkg.sv
// shared types and constants of the spi master controller
package smfc_pkg;

    localparam int CNT_W  = 24;
    localparam int LANES  = 4;
    localparam int LANE_W = 2;
    localparam int POP_W  = 3;
    localparam int FSTA_W = 7;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_RETURN = 2'd2;

    localparam logic [11:0] ADDR_GLB  = 12'h004;
    localparam logic [11:0] ADDR_TFR  = 12'h008;
    localparam logic [11:0] ADDR_FCTL = 12'h018;
    localparam logic [11:0] ADDR_FSTA = 12'h01c;
    localparam logic [11:0] ADDR_BCNT = 12'h030;
    localparam logic [11:0] ADDR_SCNT = 12'h034;
    localparam logic [11:0] ADDR_BCTL = 12'h038;
    localparam logic [11:0] ADDR_TXD  = 12'h200;
    localparam logic [11:0] ADDR_RXD  = 12'h300;

    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    typedef struct packed {
        logic             clear;
        logic             push;
        logic [POP_W-1:0] pop_cnt;
    } fifo_ctl_t;

endpackage

### hdl/smfc_fifo.sv
// byte fifo in four interleaved banks, shows the four head bytes and pops pop_cnt bytes at once
module smfc_fifo #(
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  smfc_pkg::fifo_ctl_t                   ctl,
    input  logic [7:0]                            push_data,
    output logic [$clog2(DEPTH+1)-1:0]            fill,
    output logic [smfc_pkg::LANES-1:0][7:0]       head_bytes
);
    import smfc_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int ROW_W  = PTR_W - LANE_W;
    localparam int ROWS   = 2 ** ROW_W;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [POP_W-1:0]  pop_n;
    logic              push_ok;
    logic [PTR_W-1:0]  tail;
    logic [LANE_W-1:0] tail_bank;
    logic [ROW_W-1:0]  tail_row;
    logic [ROW_W-1:0]  rd_row [LANES];
    logic [7:0]        bank_data [LANES];
    logic [7:0]        byp_data_reg;

    // pops beyond the fill level take nothing
    assign pop_n   = (FILL_W'(ctl.pop_cnt) > fill_reg) ? fill_reg[POP_W-1:0] : ctl.pop_cnt;
    assign push_ok = ctl.push && (fill_reg != FILL_W'(DEPTH));
    assign tail    = head_reg + fill_reg[PTR_W-1:0];
    assign tail_bank = tail[LANE_W-1:0];
    assign tail_row  = tail[PTR_W-1:LANE_W];

    always_comb
    begin
        head_next = head_reg + PTR_W'(pop_n);
        fill_next = fill_reg + FILL_W'(push_ok) - FILL_W'(pop_n);
        if (ctl.clear)
        begin
            head_next = '0;
            fill_next = '0;
        end
    end

    // each bank reads the row holding its byte of the next head window
    always_comb
    begin
        logic [LANE_W-1:0] off;
        logic [PTR_W-1:0]  p;
        for (int b = 0; b < LANES; b++)
        begin
            off       = LANE_W'(b) - head_next[LANE_W-1:0];
            p         = head_next + PTR_W'(off);
            rd_row[b] = p[PTR_W-1:LANE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= push_data;
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_bank
        logic [7:0] bank_mem [ROWS];
        logic [7:0] rd_data_reg;
        logic       byp_reg;
        logic       wr_en;

        assign wr_en = push_ok && (tail_bank == LANE_W'(g));

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                bank_mem[tail_row] <= push_data;
            end
            rd_data_reg <= bank_mem[rd_row[g]];
            // write and read of the same slot in one cycle
            byp_reg     <= wr_en && (tail_row == rd_row[g]);
        end

        assign bank_data[g] = byp_reg ? byp_data_reg : rd_data_reg;
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            head_bytes[k] = bank_data[LANE_W'(head_reg[LANE_W-1:0] + LANE_W'(k))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    assign fill = fill_reg;

endmodule

### hdl/spi_master_fifo_controller_core.sv
// top level of the register-mapped spi master controller with byte fifos
//
// one input channel (in_valid/in_ready) carries bus reads, bus writes and
// bytes returned by the slave; one output channel (out_valid/out_ready)
// returns exactly one result per input transfer: read data, the mosi byte to
// shift out (if any), the chip select lines and the busy flag.
// an item is registered on input, executed from the input register and the
// result registered on output; one item per cycle is sustained while
// out_ready stays high. the tx and rx fifos live in four-bank memories whose
// read data is registered, read ahead from the next head pointer; a same-cycle
// write to a slot being read is forwarded.
// reset clears all control state: fifos empty, counts zero, select level high.
// when out_ready is low the finished result waits in the output register,
// one more item is held in the input register and in_ready then drops.
module spi_master_fifo_controller_core #(
    parameter int FIFO_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [11:0] address,
    input  logic [31:0] write_data,
    input  logic [2:0]  access_size,
    input  logic [7:0]  miso_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        mosi_valid,
    output logic [7:0]  mosi_byte,
    output logic        mosi_last,
    output logic [3:0]  chip_selects,
    output logic        busy_res
);
    import smfc_pkg::*;

    `include "spi_master_fifo_controller_core_macros.svh"

    localparam int FILL_W = $clog2(FIFO_BYTES + 1);

    // input register
    logic              in_valid_reg;
    logic [1:0]        action_reg;
    logic [11:0]       address_reg;
    logic [31:0]       write_data_reg;
    logic [2:0]        access_size_reg;
    logic [7:0]        miso_reg;

    // block state
    logic [1:0]        sel_reg, sel_next;
    logic              level_reg, level_next;
    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  burst_cnt_reg, burst_cnt_next;
    logic [CNT_W-1:0]  send_cnt_reg, send_cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [7:0]        held_reg, held_next;
    logic              auto_reg, auto_next;

    // output register
    logic              out_valid_reg;
    logic [31:0]       read_data_reg;
    logic              mosi_valid_reg;
    logic [7:0]        mosi_byte_reg;
    logic              mosi_last_reg;
    logic [3:0]        cs_reg;
    logic              busy_out_reg;

    logic              exec_fire;
    fifo_ctl_t         tx_ctl, rx_ctl, tx_ctl_g, rx_ctl_g;
    logic [FILL_W-1:0] tx_fill, rx_fill;
    logic [LANES-1:0][7:0] tx_bytes, rx_bytes;

    logic [31:0]       rd_val;
    logic              emit_req;
    logic [CNT_W-1:0]  e_idx;
    logic [7:0]        e_held;
    logic [7:0]        mosi_b;
    logic              mosi_l;
    logic [POP_W-1:0]  eff_size;
    logic [3:0]        cs_next;

    assign exec_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || exec_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (exec_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg      <= action;
            address_reg     <= address;
            write_data_reg  <= write_data;
            access_size_reg <= access_size;
            miso_reg        <= miso_byte;
        end
    end

    always_comb
    begin
        sel_next       = sel_reg;
        level_next     = level_reg;
        busy_next      = busy_reg;
        burst_cnt_next = burst_cnt_reg;
        send_cnt_next  = send_cnt_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        auto_next      = auto_reg;
        tx_ctl         = '0;
        rx_ctl         = '0;
        rd_val         = '0;
        emit_req       = 1'b0;
        e_idx          = '0;
        e_held         = '0;
        mosi_b         = '0;
        mosi_l         = 1'b0;
        eff_size       = '0;

        unique case (action_reg)
            ACT_READ:
            begin
                unique case (address_reg) inside
                    ADDR_TFR:
                        rd_val = {busy_reg, 23'b0, level_reg, 1'b0, sel_reg, 4'b0};
                    ADDR_BCNT:
                        rd_val = {8'b0, burst_cnt_reg};
                    ADDR_SCNT, ADDR_BCTL:
                        rd_val = {8'b0, send_cnt_reg};
                    ADDR_FSTA:
                        rd_val = {9'b0, FSTA_W'(tx_fill), 9'b0, FSTA_W'(rx_fill)};
                    ADDR_RXD:
                    begin
                        eff_size = (access_size_reg > POP_W'(LANES)) ? POP_W'(LANES)
                                                                     : access_size_reg;
                        rx_ctl.pop_cnt = eff_size;
                        // little-endian, empty slots read as zero
                        for (int k = 0; k < LANES; k++)
                        begin
                            if ((POP_W'(k) < eff_size) && (FILL_W'(k) < rx_fill))
                            begin
                                rd_val[8*k +: 8] = rx_bytes[k];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ACT_WRITE:
            begin
                unique case (address_reg) inside
                    ADDR_GLB:
                    begin
                        if (write_data_reg[31])
                        begin
                            sel_next       = '0;
                            level_next     = 1'b1;
                            busy_next      = 1'b0;
                            burst_cnt_next = '0;
                            send_cnt_next  = '0;
                            idx_next       = '0;
                            held_next      = '0;
                            auto_next      = 1'b0;
                            tx_ctl.clear   = 1'b1;
                            rx_ctl.clear   = 1'b1;
                        end
                    end
                    ADDR_TFR:
                    begin
                        sel_next   = write_data_reg[5:4];
                        level_next = write_data_reg[7];
                        if (!busy_reg && write_data_reg[31] && (burst_cnt_reg != '0))
                        begin
                            busy_next = 1'b1;
                            idx_next  = '0;
                            held_next = '0;
                            auto_next = (send_cnt_reg < burst_cnt_reg);
                            if (send_cnt_reg < burst_cnt_reg)
                            begin
                                level_next = 1'b0;
                            end
                            emit_req = 1'b1;
                        end
                    end
                    ADDR_FCTL:
                    begin
                        tx_ctl.clear = write_data_reg[31];
                        rx_ctl.clear = write_data_reg[15];
                    end
                    ADDR_BCNT:
                        burst_cnt_next = write_data_reg[CNT_W-1:0];
                    ADDR_SCNT, ADDR_BCTL:
                        send_cnt_next = write_data_reg[CNT_W-1:0];
                    ADDR_TXD:
                        tx_ctl.push = 1'b1;
                    default: ;
                endcase
            end
            ACT_RETURN:
            begin
                if (busy_reg)
                begin
                    rx_ctl.push = 1'b1;
                    if (({1'b0, idx_reg} + (CNT_W+1)'(1)) >= {1'b0, burst_cnt_reg})
                    begin
                        busy_next = 1'b0;
                        if (auto_reg)
                        begin
                            level_next = 1'b1;
                        end
                        auto_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                        emit_req = 1'b1;
                        e_idx    = idx_reg + CNT_W'(1);
                        e_held   = held_reg;
                    end
                end
            end
            default: ;
        endcase

        // mosi byte: fill past the send count, else fifo byte or last held byte
        if (emit_req)
        begin
            if (e_idx >= send_cnt_reg)
            begin
                mosi_b = IDLE_BYTE;
            end
            else if (tx_fill != '0)
            begin
                tx_ctl.pop_cnt = POP_W'(1);
                held_next      = tx_bytes[0];
                mosi_b         = tx_bytes[0];
            end
            else
            begin
                mosi_b = e_held;
            end
            mosi_l = ({1'b0, e_idx} + (CNT_W+1)'(1)) >= {1'b0, burst_cnt_reg};
        end

        cs_next = level_next ? 4'hF : ~(4'b0001 << sel_next);
    end

    assign tx_ctl_g = exec_fire ? tx_ctl : '0;
    assign rx_ctl_g = exec_fire ? rx_ctl : '0;

    smfc_fifo #(
        .DEPTH (FIFO_BYTES)
    ) u_tx_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tx_ctl_g),
        .push_data  (write_data_reg[7:0]),
        .fill       (tx_fill),
        .head_bytes (tx_bytes)
    );

    smfc_fifo #(
        .DEPTH (FIFO_BYTES)
    ) u_rx_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (rx_ctl_g),
        .push_data  (miso_reg),
        .fill       (rx_fill),
        .head_bytes (rx_bytes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= '0;
            level_reg     <= 1'b1;
            busy_reg      <= 1'b0;
            burst_cnt_reg <= '0;
            send_cnt_reg  <= '0;
            idx_reg       <= '0;
            held_reg      <= '0;
            auto_reg      <= 1'b0;
        end
        else if (exec_fire)
        begin
            sel_reg       <= sel_next;
            level_reg     <= level_next;
            busy_reg      <= busy_next;
            burst_cnt_reg <= burst_cnt_next;
            send_cnt_reg  <= send_cnt_next;
            idx_reg       <= idx_next;
            held_reg      <= held_next;
            auto_reg      <= auto_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            read_data_reg  <= rd_val;
            mosi_valid_reg <= emit_req;
            mosi_byte_reg  <= mosi_b;
            mosi_last_reg  <= mosi_l;
            cs_reg         <= cs_next;
            busy_out_reg   <= busy_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign mosi_valid   = mosi_valid_reg;
    assign mosi_byte    = mosi_byte_reg;
    assign mosi_last    = mosi_last_reg;
    assign chip_selects = cs_reg;
    assign busy_res     = busy_out_reg;

    `SMFC_ASSERT_NEXT(a_stall_holds_item, in_valid_reg && out_valid && !out_ready, in_valid_reg, "input item lost during output stall")
    `SMFC_ASSERT_SAME(a_idle_no_auto, !busy_reg, !auto_reg, "auto select set while no burst runs")
    `SMFC_ASSERT_SAME(a_fill_bound, 1'b1, (tx_fill <= FILL_W'(FIFO_BYTES)) && (rx_fill <= FILL_W'(FIFO_BYTES)), "fifo fill above depth")
    `SMFC_ASSERT_SAME(a_mosi_in_burst, out_valid && mosi_valid, busy_res, "mosi byte outside a burst")

endmodule

### dv/spi_master_fifo_controller_core_test.sv
// self-checking testbench for the spi master controller with byte fifos
module spi_master_fifo_controller_core_test;
    import smfc_pkg::*;

    localparam int FIFO_BYTES = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 850;
    localparam int MAX_REPORTS = 10;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [11:0] ADDR_UNMAPPED = 12'hFFF;

    localparam logic [31:0] SOFT_RESET = 32'h8000_0000;
    localparam logic [31:0] BURST_GO = 32'h8000_0000;
    localparam logic [31:0] TX_CLEAR = 32'h8000_0000;
    localparam logic [31:0] RX_CLEAR = 32'h0000_8000;

    typedef struct packed {
        logic [31:0] read_val;
        logic        mosi_on;
        logic [7:0]  mosi_val;
        logic        mosi_end;
        logic [3:0]  cs_lines;
        logic        busy;
    } spi_resp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [11:0] address;
    logic [31:0] write_data;
    logic [2:0]  access_size;
    logic [7:0]  miso_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic        mosi_valid;
    logic [7:0]  mosi_byte;
    logic        mosi_last;
    logic [3:0]  chip_selects;
    logic        busy_res;

    // controller state as the bus sees it
    logic [1:0]       sel_slave;
    logic             sel_level;
    logic             running;
    logic [CNT_W-1:0] burst_len;
    logic [CNT_W-1:0] send_len;
    logic [CNT_W-1:0] byte_pos;
    logic [7:0]       held_byte;
    logic             auto_cs;
    logic [7:0]       tx_fifo[$];
    logic [7:0]       rx_fifo[$];

    spi_resp_t pending_responses[$];
    int        mismatch_count = 0;
    int        useful_items = 0;
    int        idle_cycles = 0;
    int        rx_hold_req = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;

    spi_master_fifo_controller_core #(
        .FIFO_BYTES(FIFO_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .address(address),
        .write_data(write_data),
        .access_size(access_size),
        .miso_byte(miso_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .mosi_valid(mosi_valid),
        .mosi_byte(mosi_byte),
        .mosi_last(mosi_last),
        .chip_selects(chip_selects),
        .busy_res(busy_res)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic void clear_model();
        sel_slave = 2'd0;
        sel_level = 1'b1;
        running = 1'b0;
        burst_len = '0;
        send_len = '0;
        byte_pos = '0;
        held_byte = 8'd0;
        auto_cs = 1'b0;
        tx_fifo.delete();
        rx_fifo.delete();
    endfunction

    // byte shifted out at byte_pos, padding once past the send count
    function automatic void next_mosi(output logic [7:0] mosi, output logic final_byte);
        if (byte_pos >= send_len)
        begin
            mosi = IDLE_BYTE;
        end
        else
        begin
            if (tx_fifo.size() > 0)
                held_byte = tx_fifo.pop_front();
            mosi = held_byte;
        end
        final_byte = ({1'b0, byte_pos} + 25'd1 >= {1'b0, burst_len});
    endfunction

    function automatic spi_resp_t predict_spi_response(input logic [1:0] act,
                                                       input logic [11:0] addr,
                                                       input logic [31:0] wd,
                                                       input logic [2:0] size,
                                                       input logic [7:0] miso);
        spi_resp_t r;
        int n;
        r = '0;
        case (act)
            ACT_READ:
            begin
                case (addr)
                    ADDR_TFR:  r.read_val = {running, 23'd0, sel_level, 1'b0, sel_slave, 4'd0};
                    ADDR_BCNT: r.read_val = {8'd0, burst_len};
                    ADDR_SCNT, ADDR_BCTL: r.read_val = {8'd0, send_len};
                    ADDR_FSTA:
                        r.read_val = {9'd0, 7'(tx_fifo.size()), 9'd0, 7'(rx_fifo.size())};
                    ADDR_RXD:
                    begin
                        n = (size > 3'd4) ? 4 : int'(size);
                        for (int k = 0; k < n; k++)
                        begin
                            if (rx_fifo.size() > 0)
                                r.read_val[8*k +: 8] = rx_fifo.pop_front();
                        end
                    end
                    default: ;
                endcase
            end
            ACT_WRITE:
            begin
                case (addr)
                    ADDR_GLB:
                    begin
                        if (wd[31])
                            clear_model();
                    end
                    ADDR_TFR:
                    begin
                        sel_slave = wd[5:4];
                        sel_level = wd[7];
                        if (!running && wd[31] && burst_len != 0)
                        begin
                            running = 1'b1;
                            byte_pos = '0;
                            held_byte = 8'd0;
                            auto_cs = (send_len < burst_len);
                            if (auto_cs)
                                sel_level = 1'b0;
                            r.mosi_on = 1'b1;
                            next_mosi(r.mosi_val, r.mosi_end);
                        end
                    end
                    ADDR_FCTL:
                    begin
                        if (wd[31])
                            tx_fifo.delete();
                        if (wd[15])
                            rx_fifo.delete();
                    end
                    ADDR_BCNT: burst_len = wd[CNT_W-1:0];
                    ADDR_SCNT, ADDR_BCTL: send_len = wd[CNT_W-1:0];
                    ADDR_TXD:
                    begin
                        if (tx_fifo.size() < FIFO_BYTES)
                            tx_fifo.push_back(wd[7:0]);
                    end
                    default: ;
                endcase
            end
            ACT_RETURN:
            begin
                if (running)
                begin
                    if (rx_fifo.size() < FIFO_BYTES)
                        rx_fifo.push_back(miso);
                    if ({1'b0, byte_pos} + 25'd1 >= {1'b0, burst_len})
                    begin
                        running = 1'b0;
                        if (auto_cs)
                            sel_level = 1'b1;
                        auto_cs = 1'b0;
                    end
                    else
                    begin
                        byte_pos = byte_pos + 1'b1;
                        r.mosi_on = 1'b1;
                        next_mosi(r.mosi_val, r.mosi_end);
                    end
                end
            end
            default: ;
        endcase
        r.cs_lines = sel_level ? 4'hF : ~(4'b0001 << sel_slave);
        r.busy = running;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [11:0] pick_register();
        case ($urandom_range(0, 8))
            0: return ADDR_GLB;
            1: return ADDR_TFR;
            2: return ADDR_FCTL;
            3: return ADDR_FSTA;
            4: return ADDR_BCNT;
            5: return ADDR_SCNT;
            6: return ADDR_BCTL;
            7: return ADDR_TXD;
            default: return ADDR_RXD;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [11:0] addr,
                             input logic [31:0] wd, input logic [2:0] size,
                             input logic [7:0] miso);
        int gap;
        gap = (!tx_calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        address <= addr;
        write_data <= wd;
        access_size <= size;
        miso_byte <= miso;
        do @(posedge clk); while (!in_ready);
        // returns while idle and the unused action change nothing
        if (act != ACT_NONE && !(act == ACT_RETURN && !running))
            useful_items++;
        pending_responses.push_back(predict_spi_response(act, addr, wd, size, miso));
    endtask

    task automatic reg_write(input logic [11:0] addr, input logic [31:0] wd);
        send_item(ACT_WRITE, addr, wd, 3'($urandom_range(0, 7)), 8'($urandom()));
    endtask

    task automatic reg_read(input logic [11:0] addr, input logic [2:0] size);
        send_item(ACT_READ, addr, $urandom(), size, 8'($urandom()));
    endtask

    task automatic send_return(input logic [7:0] miso);
        send_item(ACT_RETURN, 12'($urandom_range(0, 4095)), $urandom(),
                  3'($urandom_range(0, 7)), miso);
    endtask

    task automatic send_noise();
        logic [11:0] addr;
        addr = $urandom_range(0, 1) ? pick_register() : 12'($urandom_range(0, 4095));
        send_item(2'($urandom_range(0, 3)), addr, $urandom(), 3'($urandom_range(0, 7)),
                  8'($urandom()));
    endtask

    task automatic fill_tx(input int count);
        repeat (count) reg_write(ADDR_TXD, $urandom());
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_register_access();
        reg_write(ADDR_BCNT, 32'hFFFF_FFFF);
        reg_read(ADDR_BCNT, 3'd4);
        reg_write(ADDR_SCNT, 32'h5A00_0001);
        reg_read(ADDR_SCNT, 3'd4);
        reg_write(ADDR_BCTL, 32'h00FF_FFFF);
        reg_read(ADDR_BCTL, 3'd4);
        reg_read(ADDR_GLB, 3'd4);
        reg_read(ADDR_UNMAPPED, 3'd4);
        reg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        send_item(ACT_NONE, ADDR_UNMAPPED, 32'hFFFF_FFFF, 3'd7, 8'hFF);
        // start with a zero burst count does nothing but move the selects
        reg_write(ADDR_BCNT, 32'd0);
        reg_write(ADDR_TFR, BURST_GO | 32'h0000_00B0);
        reg_read(ADDR_TFR, 3'd4);
        wait_idle();
    endtask

    task automatic test_burst_sequence();
        reg_write(ADDR_FCTL, TX_CLEAR | RX_CLEAR);
        reg_write(ADDR_TXD, 32'hFFFF_FF00);
        reg_write(ADDR_TXD, 32'h0000_00A5);
        reg_write(ADDR_BCNT, 32'd4);
        reg_write(ADDR_SCNT, 32'd3);
        reg_write(ADDR_TFR, BURST_GO | 32'h0000_0010);
        // start while busy only updates the selects
        reg_write(ADDR_TFR, BURST_GO | 32'h0000_00A0);
        send_return(8'h00);
        // tx fifo now empty, so the held byte repeats
        send_return(8'hFF);
        reg_read(ADDR_TFR, 3'd4);
        send_return(8'h5A);
        send_return(8'hC3);
        send_return(8'h77);
        reg_read(ADDR_FSTA, 3'd4);
        reg_read(ADDR_RXD, 3'd0);
        reg_read(ADDR_RXD, 3'd7);
        reg_read(ADDR_RXD, 3'd1);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering transfers
    task automatic test_backpressure();
        tx_calm = 1'b1;
        rx_hold_req = 400;
        for (int i = 0; i < 48; i++)
        begin
            case (i % 3)
                0: reg_write(ADDR_TXD, $urandom());
                1: reg_read(ADDR_FSTA, 3'd4);
                default: reg_read(ADDR_TFR, 3'd4);
            endcase
        end
        tx_calm = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int start;
        int len;
        int snd;
        int n;
        int pick;
        start = useful_items;
        while (useful_items - start < RANDOM_ITEMS)
        begin
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
                snd = $urandom_range(0, len + 2);
                fill_tx($urandom_range(0, snd + 1));
                reg_write(ADDR_BCNT, {8'($urandom()), 24'(len)});
                reg_write($urandom_range(0, 1) ? ADDR_SCNT : ADDR_BCTL,
                          {8'($urandom()), 24'(snd)});
                reg_write(ADDR_TFR, $urandom() | BURST_GO);
                n = 0;
                while (running && n < 200)
                begin
                    case ($urandom_range(0, 59))
                        0: send_noise();
                        // count moved near the current byte, often ending the burst early
                        1: reg_write(ADDR_BCNT, 32'(byte_pos) + $urandom_range(0, 2));
                        2: reg_write(ADDR_GLB, SOFT_RESET);
                        3: reg_read(ADDR_RXD, 3'($urandom_range(0, 7)));
                        4: reg_write(ADDR_TXD, $urandom());
                        default: send_return(8'($urandom()));
                    endcase
                    n++;
                end
                // noise can leave a huge count behind
                if (running)
                begin
                    reg_write(ADDR_BCNT, 32'd1);
                    send_return(8'($urandom()));
                end
                // sometimes leave rx bytes behind so the rx fifo fills up
                if ($urandom_range(0, 9) < 7)
                begin
                    while (rx_fifo.size() != 0)
                        reg_read(ADDR_RXD, 3'($urandom_range(1, 7)));
                end
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4)) send_noise();
            end
            else if (pick < 93)
            begin
                fill_tx($urandom_range(1, 70));
            end
            else
            begin
                reg_write($urandom_range(0, 1) ? ADDR_GLB : ADDR_FCTL, $urandom());
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_idle();
    endtask

    initial
    begin : receiver
        int stall_left;
        int hold_left;
        out_ready = 1'b0;
        stall_left = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_responses
        spi_resp_t seen;
        spi_resp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {read_data, mosi_valid, mosi_byte, mosi_last, chip_selects, busy_res};
            if (pending_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: read_data %h mosi %b/%h/%b cs %h busy %b",
                             read_data, mosi_valid, mosi_byte, mosi_last, chip_selects,
                             busy_res);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("result error: read_data %h/%h mosi_valid %b/%b mosi_byte %h/%h",
                                 want.read_val, seen.read_val, want.mosi_on, seen.mosi_on,
                                 want.mosi_val, seen.mosi_val);
                        $display("  (expected/actual) mosi_last %b/%b cs %h/%h busy %b/%b",
                                 want.mosi_end, seen.mosi_end, want.cs_lines, seen.cs_lines,
                                 want.busy, seen.busy);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("spi_master_fifo_controller_core: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_READ;
        address = '0;
        write_data = '0;
        access_size = '0;
        miso_byte = '0;
        clear_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_register_access();
        test_burst_sequence();
        test_backpressure();
        test_random_traffic();
        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("spi_master_fifo_controller_core: match");
        else
            $display("spi_master_fifo_controller_core: mismatch");
        $finish;
    end

endmodule

### spi_master_fifo_controller_core.f
+incdir+hdl
hdl/smfc_pkg.sv
hdl/smfc_fifo.sv
hdl/spi_master_fifo_controller_core.sv
dv/spi_master_fifo_controller_core_test.sv
